### src/scmd_pkg.sv
// ---------------------------------------------------------------------------
// scmd_pkg: shared types and constants for the stereo chorus
// Payload structs, register indexes, sequencer states, fixed widths.
// ---------------------------------------------------------------------------
package scmd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 24;
  localparam int COEF_FRAC   = COEF_BITS - 2;
  localparam int DELAY_DEPTH = 32768;
  localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
  localparam int CFG_BITS    = 24;
  localparam int IDX_BITS    = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_BASE_DELAY = 3'd0,
    REG_DEPTH      = 3'd1,
    REG_PHASE_STEP = 3'd2,
    REG_WET_MIX    = 3'd3,
    REG_GAIN       = 3'd4,
    REG_FB_ONE     = 3'd5,
    REG_FB_TWO     = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic [22:0] base_delay;
    logic [20:0] depth_amount;
    logic [23:0] phase_step;
    logic [15:0] wet_mix;
    logic signed [COEF_BITS-1:0] gain;
    logic signed [COEF_BITS-1:0] fb_one;
    logic signed [COEF_BITS-1:0] fb_two;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_WRITE, ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4,
    ST_MOD, ST_ADDR, ST_RD1, ST_RD2, ST_INT0, ST_INT1, ST_FB0, ST_FY,
    ST_FA1, ST_FV, ST_MX0, ST_MX1, ST_NEXT, ST_OUT
  } state_t;

  // Sign-saturate a 64 bit value to the sample width.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2 ** (SAMPLE_BITS - 1) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    else if (v < lo) return lo[SAMPLE_BITS-1:0];
    else return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

### src/scmd_regs.sv
// ---------------------------------------------------------------------------
// scmd_regs: configuration register file
// Holds the seven control registers; writes beyond the list are dropped.
// ---------------------------------------------------------------------------
module scmd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [scmd_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [scmd_pkg::CFG_BITS-1:0] cfg_data,
  output scmd_pkg::cfg_t                cfg
);
  import scmd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_delay   <= 23'd86016;
      cfg.depth_amount <= '0;
      cfg.phase_step   <= 24'd280;
      cfg.wet_mix      <= 16'd16384;
      cfg.gain         <= 24'sd273007;
      cfg.fb_one       <= -24'sd4865393;
      cfg.fb_two       <= 24'sd1763285;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_BASE_DELAY: cfg.base_delay   <= cfg_data[22:0];
        REG_DEPTH:      cfg.depth_amount <= cfg_data[20:0];
        REG_PHASE_STEP: cfg.phase_step   <= cfg_data;
        REG_WET_MIX:    cfg.wet_mix      <= cfg_data[15:0];
        REG_GAIN:       cfg.gain         <= cfg_data;
        REG_FB_ONE:     cfg.fb_one       <= cfg_data;
        REG_FB_TWO:     cfg.fb_two       <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

### src/scmd_datapath.sv
// ---------------------------------------------------------------------------
// scmd_datapath: sequenced arithmetic over the delay store
// Owns the delay and history memories, sine, interpolation, biquad and mix.
// ---------------------------------------------------------------------------
module scmd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  scmd_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  scmd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scmd_pkg::out_item_t out_data
);
  import scmd_pkg::*;

  state_t state, state_next;

  // store: left in [47:24], right in [23:0]
  logic [2*SAMPLE_BITS-1:0] store [DELAY_DEPTH];
  logic [2*SAMPLE_BITS-1:0] rd_q;
  logic [ADDR_BITS-1:0]     addr;
  logic                     we;
  logic [2*SAMPLE_BITS-1:0] wdata;

  // filter history, one entry per channel and tap: {ch, tap}
  logic signed [31:0] hist [4];

  logic [ADDR_BITS-1:0] wp, clr;
  logic [23:0]          phase;
  logic                 ch;       // 0 left, 1 right
  in_item_t             item;
  logic signed [SAMPLE_BITS-1:0] res_l;

  // working registers
  logic [21:0]          r_q;      // reduced quarter-wave phase
  logic                 neg;
  logic [16:0]          x;
  logic [31:0]          acc;
  logic [16:0]          x2;
  logic [15:0]          sn;       // sine magnitude Q15
  logic signed [40:0]   rp;
  logic [7:0]           frac;
  logic signed [SAMPLE_BITS-1:0] s1, s2;
  logic signed [63:0]   t;        // product register
  logic signed [SAMPLE_BITS-1:0] xi;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [63:0]   b0x;

  // ---- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == ADDR_BITS'(DELAY_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_SIN0;
      ST_SIN0:  state_next = ST_SIN1;
      ST_SIN1:  state_next = ST_SIN2;
      ST_SIN2:  state_next = ST_SIN3;
      ST_SIN3:  state_next = ST_SIN4;
      ST_SIN4:  state_next = ST_MOD;
      ST_MOD:   state_next = ST_ADDR;
      ST_ADDR:  state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = ST_INT0;
      ST_INT0:  state_next = ST_INT1;
      ST_INT1:  state_next = ST_FB0;
      ST_FB0:   state_next = ST_FY;
      ST_FY:    state_next = ST_FA1;
      ST_FA1:   state_next = ST_FV;
      ST_FV:    state_next = ST_MX0;
      ST_MX0:   state_next = ST_MX1;
      ST_MX1:   state_next = ch ? ST_OUT : ST_NEXT;
      ST_NEXT:  state_next = ST_SIN0;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // ---- outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // ---- memory port select
  logic [ADDR_BITS-1:0] p1;
  assign p1 = rp[ADDR_BITS+7:8];
  always_comb begin
    we    = 1'b0;
    wdata = {in_data.left_in, in_data.right_in};
    addr  = p1;
    case (state)
      ST_CLEAR: begin we = 1'b1; wdata = '0; addr = clr; end
      ST_IDLE:  begin we = in_valid; addr = wp; end
      ST_RD2:   addr = p1 + ADDR_BITS'(1);
      default:  addr = p1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) store[addr] <= wdata;
    rd_q <= store[addr];
  end

  logic signed [SAMPLE_BITS-1:0] rd_ch;
  assign rd_ch = ch ? rd_q[SAMPLE_BITS-1:0] : rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // ---- sine index and reduction
  logic [23:0] ph_ch, q;
  assign ph_ch = phase + (ch ? 24'h400000 : 24'h0);
  assign q     = {ph_ch[23:16], 16'h0};

  logic [15:0] wet;
  assign wet = (cfg.wet_mix > 16'd32768) ? 16'd32768 : cfg.wet_mix;

  logic signed [63:0] delay_v, rp_raw;

  logic signed [SAMPLE_BITS-1:0] dry;
  assign dry = ch ? item.right_in : item.left_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0; wp <= '0; phase <= '0; ch <= 1'b0;
      for (int i = 0; i < 4; i++) hist[i] <= '0;
    end else begin
      case (state)
        ST_CLEAR: clr <= clr + ADDR_BITS'(1);
        ST_IDLE: if (in_valid) begin
          item <= in_data;
          ch   <= 1'b0;
        end
        ST_WRITE: ;
        ST_SIN0: begin
          neg <= q[23];
          r_q <= q[22] ? 22'(23'h400000 - {1'b0, q[21:0]}) : q[21:0];
        end
        ST_SIN1: begin
          x   <= {1'b0, r_q[21:6]} | (r_q == 22'h0 && q[22] ? 17'h10000 : 17'h0);
        end
        ST_SIN2: begin
          x2  <= 17'((34'(x) * 34'(x)) >> 16);
        end
        ST_SIN3: acc <= 32'(17'd42334 - 17'((34'(x2) * 34'd5223) >> 16));
        ST_SIN4: acc <= 32'(17'd102944 - 17'((49'(x2) * 49'(acc)) >> 16));
        ST_MOD: begin
          // acc holds t; s = (x*t)>>17, clamp
          sn <= 16'(((49'(x) * 49'(acc)) >> 17) > 49'd32767 ? 49'd32767
                 : ((49'(x) * 49'(acc)) >> 17));
        end
        ST_ADDR: begin
          rp   <= 41'(rp_raw);
          frac <= rp_raw[7:0];
        end
        ST_RD1: ;
        ST_RD2:  s1 <= rd_ch;
        ST_INT0: begin
          s2 <= rd_ch;
          t  <= 64'(s1) * 64'(10'sd256 - $signed({2'b00, frac}));
        end
        ST_INT1: xi <= SAMPLE_BITS'((t + 64'(s2) * 64'($signed({1'b0, frac}))) >>> 8);
        ST_FB0:  b0x <= 64'(xi) * 64'(cfg.gain);
        ST_FY:   y <= sat_sample((b0x >>> COEF_FRAC) + 64'(hist[{ch, 1'b0}]));
        ST_FA1:  t <= 64'(cfg.fb_one) * 64'(y);
        ST_FV: begin
          hist[{ch, 1'b0}] <= sat32((b0x >>> (COEF_FRAC - 1)) - (t >>> COEF_FRAC)
                                    + 64'(hist[{ch, 1'b1}]));
          hist[{ch, 1'b1}] <= sat32((b0x >>> COEF_FRAC)
                                    - ((64'(cfg.fb_two) * 64'(y)) >>> COEF_FRAC));
        end
        ST_MX0:  t <= 64'(dry) * 64'(17'sd32768 - $signed({1'b0, wet}));
        ST_MX1: begin
          if (ch) begin
            out_data.right_out <= sat_sample((t + 64'(y) * 64'($signed({1'b0, wet})))
                                             >>> 15);
            out_data.left_out  <= res_l;
          end else begin
            res_l <= sat_sample((t + 64'(y) * 64'($signed({1'b0, wet}))) >>> 15);
          end
        end
        ST_NEXT: ch <= 1'b1;
        ST_OUT: begin
          if (out_ready) begin
            wp    <= wp + ADDR_BITS'(1);
            phase <= phase + cfg.phase_step;
          end
        end
        default: ;
      endcase
    end
  end

  // modulation and wrapped read position, from the registered sine
  logic [36:0] mag;
  assign mag     = 37'(sn) * 37'(cfg.depth_amount);
  assign delay_v = neg ? 64'(cfg.base_delay) - 64'(mag >> 15)
                       : 64'(cfg.base_delay) + 64'(mag >> 15);
  assign rp_raw  = (64'(wp) <<< 8) - delay_v;

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready) else $error("request taken while clearing");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_owner: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept during result");
endmodule

### src/stereo_chorus_modulated_delay.sv
// ---------------------------------------------------------------------------
// stereo_chorus_modulated_delay: LFO-modulated stereo delay with biquad
// Writes each sample pair into a 32768-deep store, reads each channel at a
// sine-modulated, interpolated position, filters and mixes with the dry input.
// ---------------------------------------------------------------------------
//  channel | signals                          | moves
//  in      | in_valid/in_ready/in_data        | one stereo request
//  out     | out_valid/out_ready/out_data     | one mixed stereo pair
//  cfg     | cfg_we/cfg_index/cfg_data        | register write, no wait
//
// A request passes through the accepting step, one write, 17 sequencer steps per
// channel with one step between them over the single store port, and a result
// step that waits on out_ready.
// After reset all 32768 store entries are cleared; no request is taken then.
// A stalled result holds the block; the next request waits for it to leave.
module stereo_chorus_modulated_delay (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  scmd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scmd_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [scmd_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [scmd_pkg::CFG_BITS-1:0] cfg_data
);
  import scmd_pkg::*;

  cfg_t cfg;

  scmd_regs u_regs (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  scmd_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

### tb/chorus_checker.sv
// ---------------------------------------------------------------------------
// chorus_checker: prediction and comparison for the stereo chorus
// Watches the request and result channels, mirrors the configuration writes,
// computes each expected mixed pair and compares it with what the block sends.
// ---------------------------------------------------------------------------
module chorus_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  scmd_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  scmd_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [scmd_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [scmd_pkg::CFG_BITS-1:0] cfg_data,
  output int                            failures,
  output int                            pending,
  output int                            results_seen
);
  import scmd_pkg::*;

  localparam longint SPAN = longint'(DELAY_DEPTH) * 256;

  logic signed [31:0] hist_left [2];
  logic signed [31:0] hist_right [2];
  logic signed [SAMPLE_BITS-1:0] echo_left [DELAY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] echo_right [DELAY_DEPTH];
  logic [ADDR_BITS-1:0] wr_ptr;
  logic [23:0] phase;
  cfg_t regs;
  out_item_t mixed_q[$];

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint sine_of(logic [23:0] ph);
    longint unsigned q, quad, r, x, x2, t, s;
    q = longint'(ph[23:16]) << 16;
    quad = (q >> 22) & 3;
    r = q & 64'h3FFFFF;
    if (quad == 1 || quad == 3) r = 64'h400000 - r;
    x = r >> 6;
    x2 = (x * x) >> 16;
    t = 42334 - ((x2 * 5223) >> 16);
    t = 102944 - ((x2 * t) >> 16);
    s = ((x * t) >> 16) >> 1;
    if (s > 32767) s = 32767;
    return quad >= 2 ? -longint'(s) : longint'(s);
  endfunction

  // One channel: modulated read, interpolate, biquad, mix with the dry sample.
  function automatic longint voice(bit right, longint dry, logic [23:0] ph);
    longint sn, md, dly, rp, f, s1, s2, x, y, b0, a1, a2, b0x, w, h0, h1;
    int p1, p2;
    sn = sine_of(ph);
    md = ((sn < 0 ? -sn : sn) * longint'(regs.depth_amount)) >> 15;
    dly = longint'(regs.base_delay) + (sn < 0 ? -md : md);
    rp = (longint'(wr_ptr) * 256 - dly) % SPAN;
    if (rp < 0) rp += SPAN;
    p1 = int'((rp >> 8) % DELAY_DEPTH);
    p2 = (p1 + 1) % DELAY_DEPTH;
    f = rp & 255;
    s1 = right ? echo_right[p1] : echo_left[p1];
    s2 = right ? echo_right[p2] : echo_left[p2];
    x = floor_shift(s1 * (256 - f) + s2 * f, 8);
    b0 = regs.gain;
    a1 = regs.fb_one;
    a2 = regs.fb_two;
    h0 = right ? hist_right[0] : hist_left[0];
    h1 = right ? hist_right[1] : hist_left[1];
    b0x = b0 * x;
    y = clamp(floor_shift(b0x, COEF_FRAC) + h0, SAMPLE_BITS);
    h0 = clamp(floor_shift(b0x, COEF_FRAC - 1) - floor_shift(a1 * y, COEF_FRAC) + h1, 32);
    h1 = clamp(floor_shift(b0x, COEF_FRAC) - floor_shift(a2 * y, COEF_FRAC), 32);
    if (right) begin
      hist_right[0] = h0;
      hist_right[1] = h1;
    end else begin
      hist_left[0] = h0;
      hist_left[1] = h1;
    end
    w = regs.wet_mix > 32768 ? 32768 : regs.wet_mix;
    return clamp(floor_shift(dry * (32768 - w) + y * w, 15), SAMPLE_BITS);
  endfunction

  function automatic out_item_t chorus_pair(in_item_t req);
    out_item_t res;
    echo_left[wr_ptr] = req.left_in;
    echo_right[wr_ptr] = req.right_in;
    res.left_out = voice(1'b0, req.left_in, phase);
    res.right_out = voice(1'b1, req.right_in, phase + 24'h400000);
    wr_ptr = wr_ptr + 1'b1;
    phase = phase + regs.phase_step;
    return res;
  endfunction

  assign pending = mixed_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      foreach (echo_left[i]) begin
        echo_left[i] = '0;
        echo_right[i] = '0;
      end
      hist_left = '{0, 0};
      hist_right = '{0, 0};
      wr_ptr = '0;
      phase = '0;
      regs.base_delay = 23'd86016;
      regs.depth_amount = '0;
      regs.phase_step = 24'd280;
      regs.wet_mix = 16'd16384;
      regs.gain = 24'sd273007;
      regs.fb_one = -24'sd4865393;
      regs.fb_two = 24'sd1763285;
      mixed_q.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_BASE_DELAY: regs.base_delay = cfg_data[22:0];
          REG_DEPTH:      regs.depth_amount = cfg_data[20:0];
          REG_PHASE_STEP: regs.phase_step = cfg_data;
          REG_WET_MIX:    regs.wet_mix = cfg_data[15:0];
          REG_GAIN:       regs.gain = cfg_data;
          REG_FB_ONE:     regs.fb_one = cfg_data;
          REG_FB_TWO:     regs.fb_two = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) mixed_q.push_back(chorus_pair(in_data));
      if (out_valid && out_ready) begin
        results_seen++;
        if (mixed_q.size() == 0) begin
          $error("unexpected result %h", out_data);
          failures++;
        end else begin
          want = mixed_q.pop_front();
          if (out_data.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
            failures++;
          end
          if (out_data.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, out_data.right_out);
            failures++;
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the stereo chorus
// Drives sample-pair requests and register writes through several settings,
// idles both sides at random and leaves checking to chorus_checker.
// ---------------------------------------------------------------------------
module testbench;
  import scmd_pkg::*;

  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  int failures, pending, results_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_results = 1'b0;
  int quiet_cycles = 0;
  int requests_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stereo_chorus_modulated_delay DUT (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  chorus_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .failures, .pending, .results_seen
  );

  // Receiver: stall at the current rate, or hold off entirely while asked.
  always @(posedge clk) begin
    out_ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles with no request or result accepted. The clearing
  // pass after reset and the long hold-off both sit well inside the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("timeout after %0d idle cycles, %0d results pending", quiet_cycles, pending);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offer one request, with a random gap first, and hold it until taken.
  // Valid stays high after the accept; a gap or a drain drops it.
  task automatic send_pair(logic [23:0] l, logic [23:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {l, r};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Wait for every result to come back and let the sequencer settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic load_setting(logic [22:0] base, logic [20:0] depth, logic [23:0] step,
                              logic [15:0] wet, logic [23:0] g, logic [23:0] f1,
                              logic [23:0] f2);
    write_reg(REG_BASE_DELAY, base);
    write_reg(REG_DEPTH, depth);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_WET_MIX, wet);
    write_reg(REG_GAIN, g);
    write_reg(REG_FB_ONE, f1);
    write_reg(REG_FB_TWO, f2);
    cfg_we <= 1'b0;
  endtask

  // Mostly musical-size samples, with a share of full-scale and random bits.
  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'($urandom());
      default: return 24'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic random_run(int n);
    repeat (n) send_pair(pick_sample(), pick_sample());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset setting, extremes of the samples, short delays.
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
    send_pair(24'h000000, 24'hFFFFFF);
    send_pair(24'h555555, 24'hAAAAAA);
    drain();
    // Zero delay reads the sample just written; fully wet; unity-ish filter.
    load_setting(23'd0, 21'd0, 24'd0, 16'd32768, 24'h400000, 24'd0, 24'd0);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h123456, 24'hEDCBA9);
    drain();
    // Oversized delay and deepest modulation wrap the read position; wet above
    // full acts as fully wet; extreme coefficients saturate the filter state.
    load_setting(23'h7FFF00, 21'h1FFFFF, 24'h800000, 16'hFFFF, 24'h7FFFFF,
                 24'h800000, 24'h7FFFFF);
    repeat (6) send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
    drain();
    // Fully dry; extreme coefficients: most negative gain and fb_two, most positive fb_one.
    load_setting(23'd256, 21'd1000, 24'h7FFFFF, 16'd0, 24'h800000, 24'h7FFFFF, 24'h800000);
    repeat (4) send_pair(pick_sample(), pick_sample());
    drain();

    // Random, first phase: sender idles little, receiver a lot.
    load_setting(23'd86016, 21'd51200, 24'd2800, 16'd16384, 24'd273007,
                 -24'sd4865393, 24'd1763285);
    send_idle_pct = 6;
    recv_idle_pct = 54;
    random_run(500);

    // Long hold-off on the results while requests keep coming.
    hold_results = 1'b1;
    fork
      random_run(4);
      begin
        repeat (600) @(posedge clk);
        hold_results = 1'b0;
      end
    join
    drain();

    // Second phase: the other way round, short base delay, fast LFO.
    load_setting(23'd512, 21'd200000, 24'd150000, 16'd24000, 24'd1200000,
                 -24'sd3000000, 24'd900000);
    send_idle_pct = 54;
    recv_idle_pct = 6;
    random_run(500);
    drain();

    // Third phase: no idling, random setting; depth and coefficients span their full ranges, the others part of theirs.
    load_setting(23'($urandom_range(8388352)), 21'($urandom()),
                 24'($urandom_range(8388608)), 16'($urandom_range(32768)),
                 24'($urandom()), 24'($urandom()), 24'($urandom()));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_run(420);
    drain();
    load_setting(23'd86016, 21'd60000, 24'd280, 16'd32768, 24'd273007,
                 -24'sd4865393, 24'd1763285);
    random_run(400);
    drain();

    $display("covered %0d stereo requests and %0d results over eight register settings,",
             requests_sent, results_seen);
    $display("with idling on either side, a long result stall and wrapped read positions");
    if (failures == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

### stereo_chorus_modulated_delay.f
src/scmd_pkg.sv
src/scmd_regs.sv
src/scmd_datapath.sv
src/stereo_chorus_modulated_delay.sv
tb/chorus_checker.sv
tb/testbench.sv
